@@ rtl/core/dldq_pkg.sv @@
// Shared types and constants for the delta list delay queue.
package dldq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int ID_W            = 8;
  localparam int DELTA_W         = 24;
  localparam int TICK_W          = 32;
  localparam int NRES_W          = $clog2(MAX_RESULTS + 1);

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] KIND_ADD_OK   = 2'd0;
  localparam logic [1:0] KIND_ADD_FULL = 2'd1;
  localparam logic [1:0] KIND_EXPIRED  = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [ID_W-1:0]    thread_id;
    logic [DELTA_W-1:0] delay_ticks;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   thread_id_res;
    logic [TICK_W-1:0] tick_count;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DELTA_W-1:0] delta;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS,
    ST_TK_RD,
    ST_TK_CHK,
    ST_TK_END
  } state_t;

endpackage

@@ rtl/core/dldq_ram.sv @@
// Circular entry store: logical queue positions mapped from the head pointer.
module dldq_ram
  import dldq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] head,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  entry_t           wr_data
);

  entry_t mem [QUEUE_DEPTH];

  logic [IDX_W:0]   rd_sum;
  logic [IDX_W:0]   wr_sum;
  logic [IDX_W-1:0] rd_phys;
  logic [IDX_W-1:0] wr_phys;

  always_comb begin
    rd_sum = {1'b0, head} + {1'b0, rd_idx};
    wr_sum = {1'b0, head} + {1'b0, wr_idx};
    if (rd_sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      rd_sum = rd_sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    if (wr_sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      wr_sum = wr_sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    rd_phys = rd_sum[IDX_W-1:0];
    wr_phys = wr_sum[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_phys] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_phys];
    end
  end

endmodule

@@ rtl/core/delta_list_delay_queue.sv @@
// Delta list delay queue: sorted timer queue with relative delays in a circular RAM.
// Add: walks the entries to find the slot, shifts later entries up, then inserts; one word out.
// Tick: decrements the head delta and pops expired entries; up to MAX_RESULTS words out.
// Full-queue refusal is answered in the cycle after the request. Work is bounded by one RAM access per cycle.
// Results are single-cycle strobes; the receiver cannot stall.
// Synchronous reset empties the queue and clears the tick counter; RAM contents are not cleared.
module delta_list_delay_queue
  import dldq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_data,
  output logic      out_valid,
  output out_word_t out_data
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [DELTA_W-1:0] rem_r, rem_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [NRES_W-1:0]  nres_r, nres_nxt;
  logic               dec_r, dec_nxt;
  logic               pend_r, pend_nxt;
  logic [ID_W-1:0]    pend_id_r, pend_id_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_r, out_nxt;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_idx;
  entry_t             rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  entry_t             wr_data;
  logic [DELTA_W-1:0] dd;
  logic               accept;

  dldq_ram #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ram (
    .clk     (clk),
    .head    (head_r),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      tick_r      <= '0;
      nres_r      <= '0;
      dec_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tick_r      <= tick_nxt;
      nres_r      <= nres_nxt;
      dec_r       <= dec_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    idx_r     <= idx_nxt;
    rem_r     <= rem_nxt;
    id_r      <= id_nxt;
    pend_id_r <= pend_id_nxt;
    out_r     <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    tick_nxt      = tick_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    id_nxt        = id_r;
    nres_nxt      = nres_r;
    dec_nxt       = dec_r;
    pend_nxt      = pend_r;
    pend_id_nxt   = pend_id_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_idx        = '0;
    wr_en         = 1'b0;
    wr_idx        = '0;
    wr_data       = rd_data;
    dd            = (!dec_r && rd_data.delta != '0) ? rd_data.delta - 1'b1 : rd_data.delta;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.operation == OP_TICK) begin
            tick_nxt  = tick_r + 1'b1;
            nres_nxt  = '0;
            dec_nxt   = 1'b0;
            pend_nxt  = 1'b0;
            state_nxt = ST_TK_RD;
          end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{KIND_ADD_FULL, in_data.thread_id, tick_r, 1'b1};
          end else begin
            id_nxt    = in_data.thread_id;
            rem_nxt   = in_data.delay_ticks;
            pos_nxt   = '0;
            state_nxt = ST_ADD_RD;
          end
        end
      end
      ST_ADD_RD: begin
        if (CNT_W'(pos_r) == count_r) begin
          idx_nxt   = IDX_W'(count_r);
          state_nxt = ST_SH_RD;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = pos_r;
          state_nxt = ST_ADD_CMP;
        end
      end
      ST_ADD_CMP: begin
        if (rem_r < rd_data.delta) begin
          idx_nxt   = IDX_W'(count_r);
          state_nxt = ST_SH_RD;
        end else begin
          rem_nxt   = rem_r - rd_data.delta;
          pos_nxt   = pos_r + 1'b1;
          state_nxt = ST_ADD_RD;
        end
      end
      ST_SH_RD: begin
        if (idx_r == pos_r) begin
          state_nxt = ST_INS;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = idx_r - 1'b1;
          state_nxt = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        wr_en  = 1'b1;
        wr_idx = idx_r;
        // old occupant of the insert slot absorbs the new remainder
        if (idx_r - 1'b1 == pos_r) begin
          wr_data.delta = rd_data.delta - rem_r;
        end
        idx_nxt   = idx_r - 1'b1;
        state_nxt = ST_SH_RD;
      end
      ST_INS: begin
        wr_en         = 1'b1;
        wr_idx        = pos_r;
        wr_data       = '{id_r, rem_r};
        count_nxt     = count_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_nxt       = '{KIND_ADD_OK, id_r, tick_r, 1'b1};
        state_nxt     = ST_IDLE;
      end
      ST_TK_RD: begin
        if (count_r == '0 || nres_r == NRES_W'(MAX_RESULTS)) begin
          state_nxt = ST_TK_END;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = '0;
          state_nxt = ST_TK_CHK;
        end
      end
      ST_TK_CHK: begin
        dec_nxt = 1'b1;
        if (dd == '0) begin
          // expired word is held back until we know whether it is the last
          if (pend_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{KIND_EXPIRED, pend_id_r, tick_r, 1'b0};
          end
          pend_nxt    = 1'b1;
          pend_id_nxt = rd_data.id;
          head_nxt    = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_nxt   = count_r - 1'b1;
          nres_nxt    = nres_r + 1'b1;
          state_nxt   = ST_TK_RD;
        end else begin
          wr_en         = 1'b1;
          wr_idx        = '0;
          wr_data.delta = dd;
          state_nxt     = ST_TK_END;
        end
      end
      ST_TK_END: begin
        out_valid_nxt = 1'b1;
        if (pend_r) begin
          out_nxt = '{KIND_EXPIRED, pend_id_r, tick_r, 1'b1};
        end else begin
          out_nxt = '{KIND_NONE, ID_W'(0), tick_r, 1'b1};
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
